### hw/rtl/rgbx_pkg.sv
// Shared types and constants of the raw image to RGB expander.
package rgbx_pkg;

  localparam int unsigned FMT_W   = 2;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [FMT_W-1:0] FMT_MONO8  = 2'd0;
  localparam logic [FMT_W-1:0] FMT_RGB8   = 2'd1;
  localparam logic [FMT_W-1:0] FMT_BAYER8 = 2'd2;

  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [FMT_W-1:0] RESET_FORMAT = FMT_MONO8;
  localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd480;

  localparam logic [1:0] PHASE_RED   = 2'd0;
  localparam logic [1:0] PHASE_GREEN = 2'd1;
  localparam logic [1:0] PHASE_BLUE  = 2'd2;

  localparam logic [1:0] CNT_ONE  = 2'd0;
  localparam logic [1:0] CNT_TWO  = 2'd1;
  localparam logic [1:0] CNT_FOUR = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [POS_W-1:0] col0;
    logic [POS_W-1:0] col1;
    logic [POS_W-1:0] row0;
    logic [POS_W-1:0] row1;
    logic             col0_end;
    logic             col1_end;
    logic             row0_end;
    logic             row1_end;
    logic [1:0]       count_m1;
  } quad_t;

endpackage

### hw/rtl/raw_image_to_rgb_expander.sv
// Raw camera byte stream to RGB pixel expander, top level.
//
// Usage: program pixel_format, frame_width and frame_height over the cfg_ APB
// port while the block is idle; every register write restarts the frame at
// column 0, row 0. Raw bytes enter on in_valid/in_raw_byte in raster order and
// are taken at an edge where in_valid is high and in_stall low. Pixels leave on
// out_valid with colour, column, row, run_last (last pixel of one input byte)
// and frame_done (pixel at the bottom-right corner).
// A byte is registered in the compute stage and its pixels in the output stage.
// Throughput: one byte per cycle for mono8, rgb8 and even Bayer rows while
// out_stall is low. An odd Bayer row gives four pixels per two bytes and the
// output port sends one pixel per cycle, so those rows take bytes more slowly.
// The even Bayer row sits in a line buffer of MAX_WIDTH bytes, written on even
// rows but the last, and read on odd rows into a register ready with the byte.
// Reset: registers take mono8, 640 x 480; position, phase and held samples
// clear. No clearing pass over the line buffer is needed.
// Stall: while out_stall holds a pixel, the output stage keeps it, the compute
// stage waits and in_stall rises once the compute stage is full.
module raw_image_to_rgb_expander #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [rgbx_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [rgbx_pkg::PDATA_W-1:0] cfg_pwdata,
  output logic [rgbx_pkg::PDATA_W-1:0] cfg_prdata,
  output logic                         cfg_pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rgbx_pkg::PIX_W-1:0]   in_raw_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rgbx_pkg::PIX_W-1:0]   out_red,
  output logic [rgbx_pkg::PIX_W-1:0]   out_green,
  output logic [rgbx_pkg::PIX_W-1:0]   out_blue,
  output logic [rgbx_pkg::POS_W-1:0]   out_pixel_column,
  output logic [rgbx_pkg::POS_W-1:0]   out_pixel_row,
  output logic                         out_run_last,
  output logic                         out_frame_done
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned WWW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HWW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned EWW = (WWW > rgbx_pkg::DIM_W) ? WWW : rgbx_pkg::DIM_W;
  localparam int unsigned EHW = (HWW > rgbx_pkg::DIM_W) ? HWW : rgbx_pkg::DIM_W;

  // configuration registers
  logic [rgbx_pkg::FMT_W-1:0] fmt_r;
  logic [rgbx_pkg::DIM_W-1:0] width_r;
  logic [rgbx_pkg::DIM_W-1:0] height_r;
  logic                       cfg_wr;
  logic [1:0]                 cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= rgbx_pkg::RESET_FORMAT;
      width_r  <= rgbx_pkg::RESET_WIDTH;
      height_r <= rgbx_pkg::RESET_HEIGHT;
    end else if (cfg_wr) begin
      case (cfg_idx)
        rgbx_pkg::REG_FORMAT: fmt_r    <= cfg_pwdata[rgbx_pkg::FMT_W-1:0];
        rgbx_pkg::REG_WIDTH:  width_r  <= cfg_pwdata[rgbx_pkg::DIM_W-1:0];
        rgbx_pkg::REG_HEIGHT: height_r <= cfg_pwdata[rgbx_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      rgbx_pkg::REG_FORMAT: cfg_prdata = rgbx_pkg::PDATA_W'(fmt_r);
      rgbx_pkg::REG_WIDTH:  cfg_prdata = rgbx_pkg::PDATA_W'(width_r);
      rgbx_pkg::REG_HEIGHT: cfg_prdata = rgbx_pkg::PDATA_W'(height_r);
      default:              cfg_prdata = '0;
    endcase
  end

  // saturated frame size, kept as last column and last row
  logic [EWW-1:0] w_ext;
  logic [EHW-1:0] h_ext;
  logic [EWW-1:0] w_eff;
  logic [EHW-1:0] h_eff;
  logic [CW-1:0]  wm1;
  logic [RW-1:0]  hm1;

  always_comb begin
    w_ext = EWW'(width_r);
    h_ext = EHW'(height_r);
    if (w_ext == '0) begin
      w_eff = EWW'(1);
    end else if (w_ext > EWW'(MAX_WIDTH)) begin
      w_eff = EWW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (h_ext == '0) begin
      h_eff = EHW'(1);
    end else if (h_ext > EHW'(MAX_HEIGHT)) begin
      h_eff = EHW'(MAX_HEIGHT);
    end else begin
      h_eff = h_ext;
    end
    wm1 = CW'(w_eff - EWW'(1));
    hm1 = RW'(h_eff - EHW'(1));
  end

  // front stage: position, byte phase, line buffer access
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [1:0]    phase_r;
  logic          restart;
  logic [CW-1:0] col_e;
  logic [RW-1:0] row_e;
  logic [1:0]    ph_e;
  logic          col_last;
  logic          row_last;
  logic          adv;
  logic [1:0]    ph_nxt;
  logic          in_accept;
  logic          is_bayer;
  logic          mem_wr;
  logic          mem_rd;
  logic [rgbx_pkg::PIX_W-1:0] mem_q;

  assign restart  = (col_r > wm1) || (row_r > hm1);
  assign col_e    = restart ? '0 : col_r;
  assign row_e    = restart ? '0 : row_r;
  assign ph_e     = restart ? rgbx_pkg::PHASE_RED : phase_r;
  assign col_last = (col_e == wm1);
  assign row_last = (row_e == hm1);
  assign is_bayer = (fmt_r == rgbx_pkg::FMT_BAYER8);

  always_comb begin
    adv    = 1'b0;
    ph_nxt = ph_e;
    case (fmt_r)
      rgbx_pkg::FMT_MONO8:  adv = 1'b1;
      rgbx_pkg::FMT_BAYER8: adv = 1'b1;
      rgbx_pkg::FMT_RGB8: begin
        if (ph_e == rgbx_pkg::PHASE_BLUE) begin
          adv    = 1'b1;
          ph_nxt = rgbx_pkg::PHASE_RED;
        end else begin
          ph_nxt = ph_e + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign in_accept = in_valid && !in_stall;
  assign mem_wr    = in_accept && is_bayer && !row_e[0] && !row_last;
  assign mem_rd    = in_accept && is_bayer && row_e[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      phase_r <= rgbx_pkg::PHASE_RED;
    end else if (cfg_wr && (cfg_idx == rgbx_pkg::REG_FORMAT ||
                            cfg_idx == rgbx_pkg::REG_WIDTH ||
                            cfg_idx == rgbx_pkg::REG_HEIGHT)) begin
      col_r   <= '0;
      row_r   <= '0;
      phase_r <= rgbx_pkg::PHASE_RED;
    end else if (in_accept) begin
      phase_r <= ph_nxt;
      if (adv && col_last) begin
        col_r <= '0;
        row_r <= row_last ? '0 : RW'(row_e + 1'b1);
      end else if (adv) begin
        col_r <= CW'(col_e + 1'b1);
        row_r <= row_e;
      end else begin
        col_r <= col_e;
        row_r <= row_e;
      end
    end
  end

  rgbx_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_mem (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (col_e),
    .wr_data (in_raw_byte),
    .rd_en   (mem_rd),
    .rd_addr (col_e),
    .rd_data (mem_q)
  );

  // compute stage
  logic                       s1_valid_r;
  logic [rgbx_pkg::FMT_W-1:0] s1_fmt_r;
  logic [rgbx_pkg::PIX_W-1:0] s1_byte_r;
  logic [CW-1:0]              s1_col_r;
  logic [RW-1:0]              s1_row_r;
  logic [1:0]                 s1_phase_r;
  logic                       s1_col_end_r;
  logic                       s1_row_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (!in_stall) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_fmt_r     <= fmt_r;
      s1_byte_r    <= in_raw_byte;
      s1_col_r     <= col_e;
      s1_row_r     <= row_e;
      s1_phase_r   <= ph_e;
      s1_col_end_r <= col_last;
      s1_row_end_r <= row_last;
    end
  end

  logic [rgbx_pkg::PIX_W-1:0] left_sample_r;
  logic [rgbx_pkg::PIX_W-1:0] left_sample_nxt;
  logic [rgbx_pkg::PIX_W-1:0] red_top_r;
  logic [rgbx_pkg::PIX_W-1:0] red_top_nxt;
  logic [rgbx_pkg::PIX_W-1:0] held_red_r;
  logic [rgbx_pkg::PIX_W-1:0] held_red_nxt;
  logic [rgbx_pkg::PIX_W-1:0] held_green_r;
  logic [rgbx_pkg::PIX_W-1:0] held_green_nxt;
  logic [rgbx_pkg::PIX_W:0]   pair_a;
  logic [rgbx_pkg::PIX_W:0]   pair_b;
  logic [rgbx_pkg::PIX_W-1:0] mean;
  logic [rgbx_pkg::POS_W-1:0] pos_col;
  logic [rgbx_pkg::POS_W-1:0] pos_qx;
  logic [rgbx_pkg::POS_W-1:0] pos_row;
  logic [rgbx_pkg::POS_W-1:0] pos_top;
  logic                       has_quad;
  logic                       emit_free;
  logic                       s1_go;
  rgbx_pkg::quad_t            quad;

  assign pos_col = rgbx_pkg::POS_W'(s1_col_r);
  assign pos_qx  = rgbx_pkg::POS_W'(s1_col_r & ~CW'(1));
  assign pos_row = rgbx_pkg::POS_W'(s1_row_r);
  assign pos_top = rgbx_pkg::POS_W'(s1_row_r - 1'b1);
  assign mean    = rgbx_pkg::PIX_W'((pair_a + pair_b) >> 1);

  always_comb begin
    has_quad        = 1'b0;
    left_sample_nxt = left_sample_r;
    red_top_nxt     = red_top_r;
    held_red_nxt    = held_red_r;
    held_green_nxt  = held_green_r;
    pair_a          = {1'b0, s1_byte_r};
    pair_b          = {1'b0, s1_byte_r};
    quad            = '0;
    quad.red        = s1_byte_r;
    quad.green      = s1_byte_r;
    quad.blue       = s1_byte_r;
    quad.col0       = pos_col;
    quad.col1       = pos_col;
    quad.row0       = pos_row;
    quad.row1       = pos_row;
    quad.col0_end   = s1_col_end_r;
    quad.col1_end   = s1_col_end_r;
    quad.row0_end   = s1_row_end_r;
    quad.row1_end   = s1_row_end_r;
    quad.count_m1   = rgbx_pkg::CNT_ONE;
    case (s1_fmt_r)
      rgbx_pkg::FMT_MONO8: begin
        has_quad = 1'b1;
      end
      rgbx_pkg::FMT_RGB8: begin
        case (s1_phase_r)
          rgbx_pkg::PHASE_RED:   held_red_nxt   = s1_byte_r;
          rgbx_pkg::PHASE_GREEN: held_green_nxt = s1_byte_r;
          default: begin
            has_quad   = 1'b1;
            quad.red   = held_red_r;
            quad.green = held_green_r;
          end
        endcase
      end
      rgbx_pkg::FMT_BAYER8: begin
        if (!s1_row_r[0]) begin
          if (s1_row_end_r) begin
            if (!s1_col_r[0]) begin
              left_sample_nxt = s1_byte_r;
              has_quad        = s1_col_end_r;
            end else begin
              has_quad      = 1'b1;
              pair_a        = {1'b0, left_sample_r};
              quad.red      = left_sample_r;
              quad.green    = mean;
              quad.col0     = pos_qx;
              quad.col0_end = 1'b0;
              quad.count_m1 = rgbx_pkg::CNT_TWO;
            end
          end
        end else begin
          if (!s1_col_r[0]) begin
            left_sample_nxt = s1_byte_r;
            red_top_nxt     = mem_q;
            has_quad        = s1_col_end_r;
            pair_a          = {1'b0, mem_q};
            quad.red        = mem_q;
            quad.green      = mean;
            quad.row0       = pos_top;
            quad.row0_end   = 1'b0;
            quad.count_m1   = rgbx_pkg::CNT_TWO;
          end else begin
            has_quad      = 1'b1;
            pair_a        = {1'b0, mem_q};
            pair_b        = {1'b0, left_sample_r};
            quad.red      = red_top_r;
            quad.green    = mean;
            quad.col0     = pos_qx;
            quad.col0_end = 1'b0;
            quad.row0     = pos_top;
            quad.row0_end = 1'b0;
            quad.count_m1 = rgbx_pkg::CNT_FOUR;
          end
        end
      end
      default: ;
    endcase
  end

  assign s1_go    = s1_valid_r && (!has_quad || emit_free);
  assign in_stall = s1_valid_r && !s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_sample_r <= '0;
      red_top_r     <= '0;
      held_red_r    <= '0;
      held_green_r  <= '0;
    end else if (s1_go) begin
      left_sample_r <= left_sample_nxt;
      red_top_r     <= red_top_nxt;
      held_red_r    <= held_red_nxt;
      held_green_r  <= held_green_nxt;
    end
  end

  rgbx_quad_emit u_quad_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (s1_go && has_quad),
    .quad             (quad),
    .free             (emit_free),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_pixel_column (out_pixel_column),
    .out_pixel_row    (out_pixel_row),
    .out_run_last     (out_run_last),
    .out_frame_done   (out_frame_done)
  );

`ifndef SYNTHESIS
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && has_quad && !emit_free))
    else $error("input stalled with compute stage free");
  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r <= wm1) && (row_r <= hm1))
    else $error("position beyond frame");
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && cfg_idx == rgbx_pkg::REG_WIDTH) |=>
      (col_r == '0 && row_r == '0 && phase_r == rgbx_pkg::PHASE_RED))
    else $error("register write did not restart frame");
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 2'd3)
    else $error("rgb byte phase out of range");
`endif

endmodule

### hw/rtl/rgbx_line_mem.sv
// Line buffer memory holding the even Bayer row, registered read port.
module rgbx_line_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [rgbx_pkg::PIX_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [rgbx_pkg::PIX_W-1:0] rd_data
);

  logic [rgbx_pkg::PIX_W-1:0] mem_r [DEPTH];
  logic [rgbx_pkg::PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/rgbx_quad_emit.sv
// Output stage: holds one quad and sends its pixels one per cycle while out_stall is low.
module rgbx_quad_emit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  rgbx_pkg::quad_t            quad,
  output logic                       free,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rgbx_pkg::PIX_W-1:0] out_red,
  output logic [rgbx_pkg::PIX_W-1:0] out_green,
  output logic [rgbx_pkg::PIX_W-1:0] out_blue,
  output logic [rgbx_pkg::POS_W-1:0] out_pixel_column,
  output logic [rgbx_pkg::POS_W-1:0] out_pixel_row,
  output logic                       out_run_last,
  output logic                       out_frame_done
);

  rgbx_pkg::quad_t quad_r;
  logic            valid_r;
  logic [1:0]      idx_r;
  logic            last;
  logic            take;
  logic            row_sel;
  logic            col_sel;
  logic            col_end;
  logic            row_end;

  assign last    = (idx_r == quad_r.count_m1);
  assign take    = valid_r && !out_stall;
  assign free    = !valid_r || (take && last);
  assign col_sel = idx_r[0];
  assign row_sel = (quad_r.count_m1 == rgbx_pkg::CNT_FOUR) ? idx_r[1] : idx_r[0];
  assign col_end = col_sel ? quad_r.col1_end : quad_r.col0_end;
  assign row_end = row_sel ? quad_r.row1_end : quad_r.row0_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= 2'd0;
    end else if (take) begin
      if (last) begin
        valid_r <= 1'b0;
      end
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      quad_r <= quad;
    end
  end

  assign out_valid        = valid_r;
  assign out_red          = quad_r.red;
  assign out_green        = quad_r.green;
  assign out_blue         = quad_r.blue;
  assign out_pixel_column = col_sel ? quad_r.col1 : quad_r.col0;
  assign out_pixel_row    = row_sel ? quad_r.row1 : quad_r.row0;
  assign out_run_last     = last;
  assign out_frame_done   = col_end && row_end;

`ifndef SYNTHESIS
  a_idx_in_quad: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (idx_r <= quad_r.count_m1))
    else $error("pixel index beyond quad size");
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("quad loaded over pending pixels");
`endif

endmodule

### dv/tb_raw_image_to_rgb_expander.sv
// Testbench for the raw image to RGB expander: directed and random byte streams.
`timescale 1ns / 1ps

module tb_raw_image_to_rgb_expander;

  localparam logic [rgbx_pkg::FMT_W-1:0] FMT_NONE = 2'd3;
  localparam int unsigned LINE_DEPTH   = 4096;
  localparam int unsigned LINE_AW      = 12;
  localparam int unsigned ROW_LIMIT    = 4096;
  localparam int unsigned RANDOM_BYTES = 130;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [rgbx_pkg::PIX_W-1:0] red;
    logic [rgbx_pkg::PIX_W-1:0] green;
    logic [rgbx_pkg::PIX_W-1:0] blue;
    logic [rgbx_pkg::POS_W-1:0] column;
    logic [rgbx_pkg::POS_W-1:0] row;
    logic                       run_last;
    logic                       frame_done;
  } pixel_t;

  class pixel_ledger;
    logic [rgbx_pkg::FMT_W-1:0] fmt;
    logic [rgbx_pkg::DIM_W-1:0] width_reg;
    logic [rgbx_pkg::DIM_W-1:0] height_reg;
    logic [rgbx_pkg::PIX_W-1:0] line_store [LINE_DEPTH];
    logic [rgbx_pkg::PIX_W-1:0] left_pix;
    logic [rgbx_pkg::PIX_W-1:0] held_red;
    logic [rgbx_pkg::PIX_W-1:0] held_green;
    logic [1:0]       rgb_phase;
    int unsigned      col_pos;
    int unsigned      row_pos;
    pixel_t           pending_pixels [$];
    int unsigned      mismatches;
    int unsigned      checked;
    int unsigned      frames_seen;

    function new();
      fmt = rgbx_pkg::RESET_FORMAT;
      width_reg = rgbx_pkg::RESET_WIDTH;
      height_reg = rgbx_pkg::RESET_HEIGHT;
      foreach (line_store[i]) line_store[i] = '0;
      left_pix = '0;
      held_red = '0;
      held_green = '0;
      mismatches = 0;
      checked = 0;
      frames_seen = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      col_pos = 0;
      row_pos = 0;
      rgb_phase = rgbx_pkg::PHASE_RED;
    endfunction

    function int unsigned clamp_dim(logic [rgbx_pkg::DIM_W-1:0] v, int unsigned top);
      if (v == 0) return 1;
      if (32'(v) > top) return top;
      return 32'(v);
    endfunction

    function void apply_reg(logic [1:0] idx, int unsigned val);
      case (idx)
        rgbx_pkg::REG_FORMAT: fmt = rgbx_pkg::FMT_W'(val);
        rgbx_pkg::REG_WIDTH:  width_reg = rgbx_pkg::DIM_W'(val);
        rgbx_pkg::REG_HEIGHT: height_reg = rgbx_pkg::DIM_W'(val);
        default:    return;
      endcase
      restart_frame();
    endfunction

    function void push_pixel(int unsigned r, int unsigned g, int unsigned b,
                             int unsigned col, int unsigned row,
                             int unsigned w, int unsigned h);
      pixel_t p;
      p.red = rgbx_pkg::PIX_W'(r);
      p.green = rgbx_pkg::PIX_W'(g);
      p.blue = rgbx_pkg::PIX_W'(b);
      p.column = rgbx_pkg::POS_W'(col);
      p.row = rgbx_pkg::POS_W'(row);
      p.run_last = 1'b0;
      p.frame_done = (col == w - 1) && (row == h - 1);
      pending_pixels.insert(pending_pixels.size(), p);
    endfunction

    function void step_position(int unsigned w, int unsigned h);
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= h) row_pos = 0;
      end
    endfunction

    function void take_raw_byte(logic [rgbx_pkg::PIX_W-1:0] v);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      int unsigned qx;
      int unsigned red;
      int unsigned grn;
      int unsigned n_before;
      w = clamp_dim(width_reg, LINE_DEPTH);
      h = clamp_dim(height_reg, ROW_LIMIT);
      n_before = pending_pixels.size();
      if (col_pos >= w || row_pos >= h) restart_frame();
      c = col_pos;
      r = row_pos;
      qx = c & ~32'd1;
      case (fmt)
        rgbx_pkg::FMT_MONO8: begin
          push_pixel(32'(v), 32'(v), 32'(v), c, r, w, h);
          step_position(w, h);
        end
        rgbx_pkg::FMT_RGB8: begin
          if (rgb_phase == rgbx_pkg::PHASE_RED) begin
            held_red = v;
            rgb_phase = rgbx_pkg::PHASE_GREEN;
          end else if (rgb_phase == rgbx_pkg::PHASE_GREEN) begin
            held_green = v;
            rgb_phase = rgbx_pkg::PHASE_BLUE;
          end else begin
            push_pixel(32'(held_red), 32'(held_green), 32'(v), c, r, w, h);
            rgb_phase = rgbx_pkg::PHASE_RED;
            step_position(w, h);
          end
        end
        rgbx_pkg::FMT_BAYER8: begin
          if (r[0] == 1'b0) begin
            if (r == h - 1) begin
              if (c[0] == 1'b0) begin
                left_pix = v;
                if (c == w - 1) push_pixel(32'(v), 32'(v), 32'(v), c, r, w, h);
              end else begin
                red = 32'(left_pix);
                grn = (red + 32'(v)) >> 1;
                push_pixel(red, grn, 32'(v), qx, r, w, h);
                push_pixel(red, grn, 32'(v), c, r, w, h);
              end
            end else begin
              line_store[LINE_AW'(c)] = v;
            end
          end else begin
            if (c[0] == 1'b0) begin
              left_pix = v;
              if (c == w - 1) begin
                red = 32'(line_store[LINE_AW'(c)]);
                grn = (red + 32'(v)) >> 1;
                push_pixel(red, grn, 32'(v), c, r - 1, w, h);
                push_pixel(red, grn, 32'(v), c, r, w, h);
              end
            end else begin
              red = 32'(line_store[LINE_AW'(qx)]);
              grn = (32'(line_store[LINE_AW'(c)]) + 32'(left_pix)) >> 1;
              push_pixel(red, grn, 32'(v), qx, r - 1, w, h);
              push_pixel(red, grn, 32'(v), c, r - 1, w, h);
              push_pixel(red, grn, 32'(v), qx, r, w, h);
              push_pixel(red, grn, 32'(v), c, r, w, h);
            end
          end
          step_position(w, h);
        end
        default: ;
      endcase
      if (pending_pixels.size() > n_before)
        pending_pixels[pending_pixels.size() - 1].run_last = 1'b1;
    endfunction

    task report_error(string msg);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task compare_field(string name, int unsigned got, int unsigned want);
      if (got != want)
        report_error($sformatf("pixel %0d %s: got %0d, want %0d", checked, name, got, want));
    endtask

    task check_pixel(pixel_t got);
      pixel_t want;
      checked++;
      if (got.frame_done) frames_seen++;
      if (pending_pixels.size() == 0) begin
        report_error($sformatf("pixel %0d at (%0d,%0d) with none pending",
                               checked, got.column, got.row));
        return;
      end
      want = pending_pixels.pop_front();
      compare_field("red", 32'(got.red), 32'(want.red));
      compare_field("green", 32'(got.green), 32'(want.green));
      compare_field("blue", 32'(got.blue), 32'(want.blue));
      compare_field("pixel_column", 32'(got.column), 32'(want.column));
      compare_field("pixel_row", 32'(got.row), 32'(want.row));
      compare_field("run_last", 32'(got.run_last), 32'(want.run_last));
      compare_field("frame_done", 32'(got.frame_done), 32'(want.frame_done));
    endtask
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_psel;
  logic                           cfg_penable;
  logic                           cfg_pwrite;
  logic [rgbx_pkg::PADDR_W-1:0]   cfg_paddr;
  logic [rgbx_pkg::PDATA_W-1:0]   cfg_pwdata;
  logic [rgbx_pkg::PDATA_W-1:0]   cfg_prdata;
  logic                           cfg_pready;
  logic                           in_valid;
  logic                           in_stall;
  logic [rgbx_pkg::PIX_W-1:0]     in_raw_byte;
  logic                           out_valid;
  logic                           out_stall;
  logic [rgbx_pkg::PIX_W-1:0]     out_red;
  logic [rgbx_pkg::PIX_W-1:0]     out_green;
  logic [rgbx_pkg::PIX_W-1:0]     out_blue;
  logic [rgbx_pkg::POS_W-1:0]     out_pixel_column;
  logic [rgbx_pkg::POS_W-1:0]     out_pixel_row;
  logic                           out_run_last;
  logic                           out_frame_done;

  pixel_ledger                    ledger = new();
  pixel_t                         seen_pixel;
  logic [rgbx_pkg::PIX_W-1:0]     directed_bytes [$];
  bit                             hold_req = 1'b0;
  bit                             hold_done = 1'b0;
  int unsigned                    bytes_sent = 0;
  int unsigned                    random_count = 0;
  int unsigned                    reg_writes = 0;
  int unsigned                    cycle_count = 0;

  raw_image_to_rgb_expander DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_raw_byte      (in_raw_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_pixel_column (out_pixel_column),
    .out_pixel_row    (out_pixel_row),
    .out_run_last     (out_run_last),
    .out_frame_done   (out_frame_done)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles with %0d pixels pending",
             cycle_count, ledger.pending_pixels.size());
    $display("Verification failed");
    $finish;
  end

  initial begin : pixel_receiver
    int unsigned run_left;
    int unsigned pick;
    bit          level;
    run_left = 0;
    level = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
        run_left = 0;
      end
      if (run_left == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          level = 1'b0;
          run_left = $urandom_range(1, 6);
        end else if (pick < 70) begin
          level = 1'b0;
          run_left = $urandom_range(20, 60);
        end else if (pick < 93) begin
          level = 1'b1;
          run_left = $urandom_range(1, 3);
        end else begin
          level = 1'b1;
          run_left = $urandom_range(15, 50);
        end
      end
      out_stall = level;
      run_left--;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_pixel = '{red: out_red, green: out_green, blue: out_blue,
                     column: out_pixel_column, row: out_pixel_row,
                     run_last: out_run_last, frame_done: out_frame_done};
      ledger.check_pixel(seen_pixel);
    end
  end

  function automatic int unsigned sender_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [rgbx_pkg::PIX_W-1:0] pick_raw();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return rgbx_pkg::PIX_W'($urandom_range(0, 255));
  endfunction

  function automatic int unsigned pick_dim(int unsigned top);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick != 0) return $urandom_range(1, top);
    pick = $urandom_range(0, 2);
    if (pick == 0) return 0;
    if (pick == 1) return 4096;
    return 8191;
  endfunction

  task automatic apb_write(input logic [1:0] idx, input int unsigned val);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = rgbx_pkg::PADDR_W'({idx, 2'b00});
    cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    ledger.apply_reg(idx, val);
    reg_writes++;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic set_frame(input logic [rgbx_pkg::FMT_W-1:0] fmt, input int unsigned w,
                           input int unsigned h);
    apb_write(rgbx_pkg::REG_FORMAT, 32'(fmt));
    apb_write(rgbx_pkg::REG_WIDTH, w);
    apb_write(rgbx_pkg::REG_HEIGHT, h);
  endtask

  task automatic send_byte(input logic [rgbx_pkg::PIX_W-1:0] v, input bit gapped);
    int unsigned gap;
    gap = gapped ? sender_gap() : 0;
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_raw_byte = v;
    do @(posedge clk); while (in_stall);
    ledger.take_raw_byte(v);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_directed();
    foreach (directed_bytes[i]) send_byte(directed_bytes[i], 1'b1);
    directed_bytes.delete();
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (ledger.pending_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [rgbx_pkg::FMT_W-1:0] fmt_pick;
    int unsigned      pick;
    int unsigned      w_eff;
    int unsigned      h_eff;
    int unsigned      frame_bytes;
    int unsigned      n_bytes;
    bit               burst;
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_valid = 1'b0;
    in_raw_byte = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    set_frame(rgbx_pkg::FMT_MONO8, 3, 2);
    directed_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE};
    send_directed();
    wait_idle();

    set_frame(rgbx_pkg::FMT_RGB8, 2, 1);
    directed_bytes = '{8'h00, 8'hFF, 8'h55, 8'hFF, 8'h00, 8'hAA};
    send_directed();
    wait_idle();

    set_frame(rgbx_pkg::FMT_BAYER8, 3, 3);
    directed_bytes = '{8'hC8, 8'hFF, 8'h09, 8'hFE, 8'h11, 8'h03, 8'h00, 8'hFF, 8'h80};
    send_directed();
    wait_idle();

    apb_write(rgbx_pkg::REG_FORMAT, 32'(FMT_NONE));
    directed_bytes = '{8'h3C, 8'hC3};
    send_directed();
    wait_idle();

    set_frame(rgbx_pkg::FMT_MONO8, 0, 0);
    directed_bytes = '{8'h00, 8'hFF};
    send_directed();
    wait_idle();

    apb_write(rgbx_pkg::REG_FORMAT, 32'(rgbx_pkg::FMT_BAYER8));
    directed_bytes = '{8'hA5, 8'h5A};
    send_directed();
    wait_idle();

    set_frame(rgbx_pkg::FMT_MONO8, 8191, 8191);
    apb_write(rgbx_pkg::REG_HEIGHT, 4096);
    directed_bytes = '{8'h12, 8'hED, 8'h99};
    send_directed();
    wait_idle();

    hold_req = 1'b1;
    set_frame(rgbx_pkg::FMT_BAYER8, 8, 4);
    repeat (32) begin
      send_byte(pick_raw(), 1'b0);
      random_count++;
    end
    wait_idle();

    while (random_count < RANDOM_BYTES) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) fmt_pick = rgbx_pkg::FMT_MONO8;
      else if (pick < 5) fmt_pick = rgbx_pkg::FMT_RGB8;
      else if (pick < 9) fmt_pick = rgbx_pkg::FMT_BAYER8;
      else fmt_pick = FMT_NONE;
      apb_write(rgbx_pkg::REG_FORMAT, 32'(fmt_pick));
      if ($urandom_range(0, 9) < 7) apb_write(rgbx_pkg::REG_WIDTH, pick_dim(7));
      if ($urandom_range(0, 9) < 7) apb_write(rgbx_pkg::REG_HEIGHT, pick_dim(5));
      burst = ($urandom_range(0, 4) == 0);
      if (fmt_pick == FMT_NONE) begin
        repeat ($urandom_range(1, 4)) send_byte(pick_raw(), !burst);
      end else begin
        w_eff = ledger.clamp_dim(ledger.width_reg, LINE_DEPTH);
        h_eff = ledger.clamp_dim(ledger.height_reg, ROW_LIMIT);
        frame_bytes = w_eff * h_eff * ((fmt_pick == rgbx_pkg::FMT_RGB8) ? 3 : 1);
        if (frame_bytes <= 48) begin
          n_bytes = frame_bytes * $urandom_range(1, 2) + $urandom_range(0, frame_bytes / 2);
          if (n_bytes > 60) n_bytes = 60;
        end else begin
          n_bytes = $urandom_range(6, 24);
        end
        repeat (n_bytes) begin
          send_byte(pick_raw(), !burst);
          random_count++;
        end
      end
      wait_idle();
    end

    if (ledger.pending_pixels.size() != 0)
      ledger.report_error($sformatf("%0d pixels never arrived", ledger.pending_pixels.size()));
    $display("Sent %0d raw bytes (%0d in random frames) across %0d register writes",
             bytes_sent, random_count, reg_writes);
    $display("Checked %0d pixels, %0d frame ends, %0d mismatches",
             ledger.checked, ledger.frames_seen, ledger.mismatches);
    if (ledger.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
